@@ design/lbcd_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbcd_pkg: shared types and constants
// Operation codes, fixed field widths and the control bundles that pass
// between the sequencer, the slot store and the scan unit.
// ----------------------------------------------------------------------------
package lbcd_pkg;

   // fixed field widths of the request and response beats and of the stamps
   localparam int OP_W    = 2;
   localparam int BLOCK_W = 20;
   localparam int SLOT_W  = 6;
   localparam int STAMP_W = 32;

   // request operation codes
   localparam logic [OP_W-1:0] OP_READ  = 2'd0;
   localparam logic [OP_W-1:0] OP_WRITE = 2'd1;
   localparam logic [OP_W-1:0] OP_FLUSH = 2'd2;

   // write command into the slot store
   typedef struct packed {
      logic tag_we;
      logic stamp_we;
      logic valid_set;
      logic dirty_we;
      logic dirty_val;
   } lbcd_wr_type;

   // control of the shared compare unit
   typedef struct packed {
      logic clear;
      logic step;
   } lbcd_scan_ctl_type;

endpackage

@@ design/lbcd_store.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbcd_store: slot directory storage
// Tag and stamp memories with one write port and one registered read port,
// plus per-slot valid and dirty flags that reset clears.
// ----------------------------------------------------------------------------
module lbcd_store #(
   parameter int SLOTS    = 64,
   parameter int TAG_BITS = 20
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic [$clog2(SLOTS)-1:0]        rd_addr,
   output logic [TAG_BITS-1:0]             rd_tag_ff,
   output logic [lbcd_pkg::STAMP_W-1:0]    rd_stamp_ff,
   output logic                            rd_valid_ff,
   input  logic [$clog2(SLOTS)-1:0]        wr_addr,
   input  logic [TAG_BITS-1:0]             wr_tag,
   input  logic [lbcd_pkg::STAMP_W-1:0]    wr_stamp,
   input  lbcd_pkg::lbcd_wr_type           wr_cmd,
   output logic [SLOTS-1:0]                valid_vec,
   output logic [SLOTS-1:0]                dirty_vec
);
   import lbcd_pkg::*;

   logic [TAG_BITS-1:0] tag_mem   [SLOTS];
   logic [STAMP_W-1:0]  stamp_mem [SLOTS];
   logic [SLOTS-1:0]    valid_ff;
   logic [SLOTS-1:0]    dirty_ff;

   // write tag and stamp memories
   always_ff @(posedge clock) begin
      if (wr_cmd.tag_we) begin
         tag_mem[wr_addr] <= wr_tag;
      end
      if (wr_cmd.stamp_we) begin
         stamp_mem[wr_addr] <= wr_stamp;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rd_tag_ff   <= tag_mem[rd_addr];
      rd_stamp_ff <= stamp_mem[rd_addr];
      rd_valid_ff <= valid_ff[rd_addr];
   end

   // update valid and dirty flags
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         dirty_ff <= '0;
      end else begin
         if (wr_cmd.valid_set) begin
            valid_ff[wr_addr] <= 1'b1;
         end
         if (wr_cmd.dirty_we) begin
            dirty_ff[wr_addr] <= wr_cmd.dirty_val;
         end
      end
   end

   assign valid_vec = valid_ff;
   assign dirty_vec = dirty_ff;

endmodule

@@ design/lbcd_scan.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbcd_scan: shared slot compare unit
// Takes one slot per step and keeps the running tag match, the first free
// slot and the oldest valid slot (lowest index on equal stamps).
// ----------------------------------------------------------------------------
module lbcd_scan #(
   parameter int SLOTS    = 64,
   parameter int TAG_BITS = 20
) (
   input  logic                            clock,
   input  logic                            reset,
   input  lbcd_pkg::lbcd_scan_ctl_type     ctl,
   input  logic [$clog2(SLOTS)-1:0]        step_idx,
   input  logic                            step_valid,
   input  logic [TAG_BITS-1:0]             step_tag,
   input  logic [lbcd_pkg::STAMP_W-1:0]    step_stamp,
   input  logic [TAG_BITS-1:0]             req_tag,
   output logic                            hit_found_ff,
   output logic [$clog2(SLOTS)-1:0]        hit_idx_ff,
   output logic                            free_found_ff,
   output logic [$clog2(SLOTS)-1:0]        free_idx_ff,
   output logic [$clog2(SLOTS)-1:0]        best_idx_ff,
   output logic [TAG_BITS-1:0]             best_tag_ff
);
   import lbcd_pkg::*;

   logic               best_seen_ff;
   logic [STAMP_W-1:0] best_stamp_ff;
   logic               is_match;
   logic               is_older;

   // one tag compare and one stamp compare per step
   assign is_match = step_valid && (step_tag == req_tag);
   assign is_older = step_valid && (!best_seen_ff || (step_stamp < best_stamp_ff));

   // track hit, free slot and oldest slot
   always_ff @(posedge clock) begin
      if (reset || ctl.clear) begin
         hit_found_ff  <= 1'b0;
         free_found_ff <= 1'b0;
         best_seen_ff  <= 1'b0;
      end else if (ctl.step) begin
         if (is_match && !hit_found_ff) begin
            hit_found_ff <= 1'b1;
            hit_idx_ff   <= step_idx;
         end
         if (!step_valid && !free_found_ff) begin
            free_found_ff <= 1'b1;
            free_idx_ff   <= step_idx;
         end
         if (is_older) begin
            best_seen_ff  <= 1'b1;
            best_stamp_ff <= step_stamp;
            best_idx_ff   <= step_idx;
            best_tag_ff   <= step_tag;
         end
      end
   end

endmodule

@@ design/lru_block_cache_directory_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lru_block_cache_directory_top: fully associative LRU write-back directory
// Sequencer, response register and access counter around the slot store
// and the shared compare unit.
// ----------------------------------------------------------------------------
// In a read or write lookup, from the accepted request beat to the loaded
// response beat, one compare unit walks the slots one per cycle through the
// single registered read port of the tag and stamp memories, the drain state
// finishes the compare of the last slot, and the result state settles the
// choice and updates the slot; a beat still waiting in the response register
// delays that last step. A flush walks the same port and stops in an output
// state at each dirty slot, and each flushed slot gives its own response
// beat; a flush with no dirty slot gives none, and operation 3 is taken and
// dropped. The next request is taken once the walk is done, while the last
// response beat may still wait for rsp_ready. No clearing pass follows
// reset.
// ----------------------------------------------------------------------------
module lru_block_cache_directory_top #(
   parameter int SLOTS    = 64,
   parameter int TAG_BITS = 20
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [lbcd_pkg::OP_W-1:0]     req_operation,
   input  logic [lbcd_pkg::BLOCK_W-1:0]  req_block_number,
   input  logic                          req_backing_has_data,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [lbcd_pkg::SLOT_W-1:0]   rsp_slot,
   output logic                          rsp_hit,
   output logic                          rsp_fill,
   output logic                          rsp_write_back,
   output logic [lbcd_pkg::BLOCK_W-1:0]  rsp_victim_block,
   output logic                          rsp_last
);
   import lbcd_pkg::*;

   localparam int IDX_W = $clog2(SLOTS);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);

   localparam logic [2:0] S_IDLE    = 3'd0;
   localparam logic [2:0] S_SCAN    = 3'd1;
   localparam logic [2:0] S_DRAIN   = 3'd2;
   localparam logic [2:0] S_RESULT  = 3'd3;
   localparam logic [2:0] S_FL_SCAN = 3'd4;
   localparam logic [2:0] S_FL_OUT  = 3'd5;

   logic [2:0]          state_ff, state_in;
   logic [IDX_W-1:0]    idx_ff, idx_in;
   logic                cmp_vld_ff, cmp_vld_in;
   logic [IDX_W-1:0]    cmp_idx_ff;
   logic [OP_W-1:0]     op_ff;
   logic [TAG_BITS-1:0] req_tag_ff;
   logic                has_data_ff;
   logic [STAMP_W-1:0]  counter_ff;

   logic                rsp_valid_ff;
   logic [SLOT_W-1:0]   rsp_slot_ff;
   logic                rsp_hit_ff;
   logic                rsp_fill_ff;
   logic                rsp_wb_ff;
   logic [BLOCK_W-1:0]  rsp_victim_ff;
   logic                rsp_last_ff;

   logic [TAG_BITS-1:0] rd_tag;
   logic [STAMP_W-1:0]  rd_stamp;
   logic                rd_valid;
   logic [IDX_W-1:0]    wr_addr;
   logic [STAMP_W-1:0]  next_stamp;
   lbcd_wr_type         wr_cmd;
   logic [SLOTS-1:0]    valid_vec;
   logic [SLOTS-1:0]    dirty_vec;
   lbcd_scan_ctl_type   scan_ctl;

   logic                hit_found;
   logic [IDX_W-1:0]    hit_idx;
   logic                free_found;
   logic [IDX_W-1:0]    free_idx;
   logic [IDX_W-1:0]    best_idx;
   logic [TAG_BITS-1:0] best_tag;

   logic                req_fire;
   logic                out_free;
   logic                out_load;
   logic [IDX_W-1:0]    sel_idx;
   logic                sel_wb;
   logic                sel_fill;
   logic [SLOTS-1:0]    pend_rest;
   logic                fl_dirty;

   // slot storage
   lbcd_store #(
      .SLOTS    (SLOTS),
      .TAG_BITS (TAG_BITS)
   ) u_store (
      .clock       (clock),
      .reset       (reset),
      .rd_addr     (idx_ff),
      .rd_tag_ff   (rd_tag),
      .rd_stamp_ff (rd_stamp),
      .rd_valid_ff (rd_valid),
      .wr_addr     (wr_addr),
      .wr_tag      (req_tag_ff),
      .wr_stamp    (next_stamp),
      .wr_cmd      (wr_cmd),
      .valid_vec   (valid_vec),
      .dirty_vec   (dirty_vec)
   );

   // shared compare unit
   lbcd_scan #(
      .SLOTS    (SLOTS),
      .TAG_BITS (TAG_BITS)
   ) u_scan (
      .clock         (clock),
      .reset         (reset),
      .ctl           (scan_ctl),
      .step_idx      (cmp_idx_ff),
      .step_valid    (rd_valid),
      .step_tag      (rd_tag),
      .step_stamp    (rd_stamp),
      .req_tag       (req_tag_ff),
      .hit_found_ff  (hit_found),
      .hit_idx_ff    (hit_idx),
      .free_found_ff (free_found),
      .free_idx_ff   (free_idx),
      .best_idx_ff   (best_idx),
      .best_tag_ff   (best_tag)
   );

   // handshake terms
   assign req_ready = (state_ff == S_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   // lookup decision
   assign sel_idx    = hit_found ? hit_idx : (free_found ? free_idx : best_idx);
   assign sel_wb     = !hit_found && !free_found && dirty_vec[best_idx];
   assign sel_fill   = !hit_found && ((op_ff == OP_READ) || has_data_ff);
   assign next_stamp = counter_ff + STAMP_W'(1);

   // flush bookkeeping: dirty slots still left after this one
   assign fl_dirty  = valid_vec[idx_ff] && dirty_vec[idx_ff];
   assign pend_rest = valid_vec & dirty_vec & ~(SLOTS'(1) << idx_ff);

   assign scan_ctl.clear = req_fire;
   assign scan_ctl.step  = cmp_vld_ff;

   // sequencer
   always_comb begin
      state_in   = state_ff;
      idx_in     = idx_ff;
      cmp_vld_in = 1'b0;
      out_load   = 1'b0;
      wr_addr    = idx_ff;
      wr_cmd     = '0;
      unique case (state_ff)
         S_IDLE: begin
            idx_in = '0;
            if (req_fire) begin
               if (req_operation == OP_READ || req_operation == OP_WRITE) begin
                  state_in = S_SCAN;
               end else if (req_operation == OP_FLUSH) begin
                  state_in = S_FL_SCAN;
               end
            end
         end
         S_SCAN: begin
            cmp_vld_in = 1'b1;
            if (idx_ff == LAST_IDX) begin
               state_in = S_DRAIN;
            end else begin
               idx_in = idx_ff + IDX_W'(1);
            end
         end
         S_DRAIN: begin
            state_in = S_RESULT;
         end
         S_RESULT: begin
            wr_addr = sel_idx;
            if (out_free) begin
               out_load         = 1'b1;
               wr_cmd.stamp_we  = 1'b1;
               wr_cmd.tag_we    = !hit_found;
               wr_cmd.valid_set = !hit_found;
               wr_cmd.dirty_we  = !hit_found || (op_ff == OP_WRITE);
               wr_cmd.dirty_val = (op_ff == OP_WRITE);
               state_in         = S_IDLE;
            end
         end
         S_FL_SCAN: begin
            if (fl_dirty) begin
               state_in = S_FL_OUT;
            end else if (idx_ff == LAST_IDX) begin
               state_in = S_IDLE;
            end else begin
               idx_in = idx_ff + IDX_W'(1);
            end
         end
         S_FL_OUT: begin
            if (out_free) begin
               out_load         = 1'b1;
               wr_cmd.dirty_we  = 1'b1;
               wr_cmd.dirty_val = 1'b0;
               if (idx_ff == LAST_IDX) begin
                  state_in = S_IDLE;
               end else begin
                  idx_in   = idx_ff + IDX_W'(1);
                  state_in = S_FL_SCAN;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // hold control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         idx_ff     <= '0;
         cmp_vld_ff <= 1'b0;
         counter_ff <= '0;
      end else begin
         state_ff   <= state_in;
         idx_ff     <= idx_in;
         cmp_vld_ff <= cmp_vld_in;
         if (out_load && state_ff == S_RESULT) begin
            counter_ff <= next_stamp;
         end
      end
   end

   // capture request beat and align compare index with the read data
   always_ff @(posedge clock) begin
      cmp_idx_ff <= idx_ff;
      if (req_fire) begin
         op_ff       <= req_operation;
         req_tag_ff  <= TAG_BITS'(req_block_number);
         has_data_ff <= req_backing_has_data;
      end
   end

   // response register: load a beat, drop it once taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         if (state_ff == S_RESULT) begin
            rsp_slot_ff   <= SLOT_W'(sel_idx);
            rsp_hit_ff    <= hit_found;
            rsp_fill_ff   <= sel_fill;
            rsp_wb_ff     <= sel_wb;
            rsp_victim_ff <= sel_wb ? BLOCK_W'(best_tag) : '0;
            rsp_last_ff   <= 1'b1;
         end else begin
            rsp_slot_ff   <= SLOT_W'(idx_ff);
            rsp_hit_ff    <= 1'b0;
            rsp_fill_ff   <= 1'b0;
            rsp_wb_ff     <= 1'b1;
            rsp_victim_ff <= BLOCK_W'(rd_tag);
            rsp_last_ff   <= (pend_rest == '0);
         end
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_slot         = rsp_slot_ff;
   assign rsp_hit          = rsp_hit_ff;
   assign rsp_fill         = rsp_fill_ff;
   assign rsp_write_back   = rsp_wb_ff;
   assign rsp_victim_block = rsp_victim_ff;
   assign rsp_last         = rsp_last_ff;

endmodule
